// ===== rtl/acs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, codes and sizes of the aligned chunk splitter.
// ----------------------------------------------------------------------------
package acs_pkg;

    localparam int ADDR_W          = 32;
    localparam int WB_W            = 4;
    localparam int CW_W            = 13;
    localparam int AW_W            = 7;
    localparam int CB_W            = 16;
    localparam int AB_W            = AW_W + WB_W;
    localparam int PW_W            = 64;
    localparam int KP_W            = 3;
    localparam int MAX_ALIGN_BYTES = 64;
    localparam int QDEPTH          = 2;
    localparam int QPTR_W          = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W          = $clog2(QDEPTH + 1);
    localparam int PADDR_W         = 6;
    localparam int PDATA_W         = 64;
    localparam int REG_IDX_W       = 3;

    // input item kinds
    localparam logic [1:0] K_START = 2'd0;
    localparam logic [1:0] K_DATA  = 2'd1;
    localparam logic [1:0] K_END   = 2'd2;

    // commands from front to back
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_ERR   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_GEOM  = 2'd1;
    localparam logic [1:0] ERR_ALIGN = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_WORD_BYTES  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHUNK_WORDS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ALIGN_WORDS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAD_ENABLE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PAD_WORD    = 3'd4;

    typedef struct packed {
        logic [WB_W-1:0] word_bytes;
        logic [CW_W-1:0] chunk_words;
        logic [AW_W-1:0] align_words;
        logic            pad_enable;
        logic [PW_W-1:0] pad_word;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        err;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [AW_W-1:0]   offset;
        logic [WB_W-1:0]   wb;
        logic [AW_W-1:0]   align;
        logic [CB_W-1:0]   chunk;
        logic              pad;
        logic [PW_W-1:0]   pad_word;
    } t_cmd;

    typedef struct packed {
        logic [7:0]        value;
        logic [ADDR_W-1:0] addr;
        logic              pad;
        logic              first;
        logic              last;
        logic              run_last;
        logic [1:0]        err;
    } t_res;

endpackage

// ===== rtl/acs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_front
// Accepts input beats, checks segment geometry, finds the start offset with a
// bit-serial remainder unit and queues commands for the back end.
// ----------------------------------------------------------------------------
module acs_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_kind,
    input  logic [acs_pkg::ADDR_W-1:0] i_addr,
    input  logic [7:0]                i_data,
    input  acs_pkg::t_cfg             i_cfg,
    output logic                      o_cmd_valid,
    output acs_pkg::t_cmd             o_cmd,
    input  logic                      i_cmd_ready
);
    import acs_pkg::*;

    localparam int CNT_W = $clog2(ADDR_W);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MODC = 2'd1;
    localparam logic [1:0] F_MODA = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]        r_state, n_state;
    logic              r_in_seg, n_in_seg;
    logic [AW_W-1:0]   r_rem, n_rem;
    logic [AW_W-1:0]   r_dvs, n_dvs;
    logic [ADDR_W-1:0] r_dvd, n_dvd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_cmd              r_cmd, n_cmd;

    logic [WB_W-1:0]   wb_clamp;
    logic [AB_W-1:0]   align_bytes;
    logic [CB_W-1:0]   chunk_bytes;
    logic [AW_W:0]     rem_trial;
    logic [AW_W-1:0]   rem_step;
    logic              accept;

    always_comb begin
        if (i_cfg.word_bytes == '0) begin
            wb_clamp = WB_W'(1);
        end else if (i_cfg.word_bytes > WB_W'(8)) begin
            wb_clamp = WB_W'(8);
        end else begin
            wb_clamp = i_cfg.word_bytes;
        end
    end

    assign align_bytes = AB_W'(i_cfg.align_words) * AB_W'(wb_clamp);
    assign chunk_bytes = CB_W'(i_cfg.chunk_words) * CB_W'(wb_clamp);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_trial = {r_rem, r_dvd[ADDR_W-1]};
    assign rem_step  = (rem_trial >= {1'b0, r_dvs}) ? AW_W'(rem_trial - {1'b0, r_dvs})
                                                    : rem_trial[AW_W-1:0];

    assign o_in_ready = (r_state == F_IDLE) && i_cmd_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_in_seg    = r_in_seg;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_dvd       = r_dvd;
        n_cnt       = r_cnt;
        n_addr      = r_addr;
        n_cmd       = r_cmd;
        o_cmd_valid = 1'b0;
        o_cmd       = r_cmd;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    if (i_kind == K_START && !r_in_seg) begin
                        n_addr = i_addr;
                        if (i_cfg.align_words == '0 || i_cfg.chunk_words == '0) begin
                            n_cmd      = '0;
                            n_cmd.op   = OP_ERR;
                            n_cmd.err  = ERR_GEOM;
                            n_cmd.addr = i_addr;
                            n_state    = F_PUSH;
                        end else begin
                            n_rem   = '0;
                            n_dvs   = i_cfg.align_words;
                            n_dvd   = {i_cfg.chunk_words, {(ADDR_W - CW_W){1'b0}}};
                            n_cnt   = CNT_W'(CW_W - 1);
                            n_state = F_MODC;
                        end
                    end else if (i_kind == K_DATA && r_in_seg) begin
                        o_cmd_valid = 1'b1;
                        o_cmd       = '0;
                        o_cmd.op    = OP_DATA;
                        o_cmd.data  = i_data;
                    end else if (i_kind == K_END && r_in_seg) begin
                        o_cmd_valid = 1'b1;
                        o_cmd       = '0;
                        o_cmd.op    = OP_END;
                        n_in_seg    = 1'b0;
                    end
                end
            end
            F_MODC: begin
                n_rem = rem_step;
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    if (rem_step != '0 || align_bytes > AB_W'(MAX_ALIGN_BYTES)) begin
                        n_cmd      = '0;
                        n_cmd.op   = OP_ERR;
                        n_cmd.err  = (rem_step != '0) ? ERR_GEOM : ERR_ALIGN;
                        n_cmd.addr = r_addr;
                        n_state    = F_PUSH;
                    end else begin
                        n_rem   = '0;
                        n_dvs   = align_bytes[AW_W-1:0];
                        n_dvd   = r_addr;
                        n_cnt   = CNT_W'(ADDR_W - 1);
                        n_state = F_MODA;
                    end
                end
            end
            F_MODA: begin
                n_rem = rem_step;
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_cmd          = '0;
                    n_cmd.op       = OP_START;
                    n_cmd.addr     = r_addr;
                    n_cmd.offset   = rem_step;
                    n_cmd.wb       = wb_clamp;
                    n_cmd.align    = align_bytes[AW_W-1:0];
                    n_cmd.chunk    = chunk_bytes;
                    n_cmd.pad      = i_cfg.pad_enable;
                    n_cmd.pad_word = i_cfg.pad_word;
                    n_state        = F_PUSH;
                end
            end
            F_PUSH: begin
                o_cmd_valid = 1'b1;
                if (i_cmd_ready) begin
                    n_in_seg = (r_cmd.op == OP_START);
                    n_state  = F_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_in_seg <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_in_seg <= n_in_seg;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_dvd  <= n_dvd;
        r_addr <= n_addr;
        r_cmd  <= n_cmd;
    end

endmodule

// ===== rtl/acs_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_fifo
// Short command queue between the front and back ends, show-ahead read.
// ----------------------------------------------------------------------------
module acs_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  acs_pkg::t_cmd i_data,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output acs_pkg::t_cmd o_data
);
    import acs_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/acs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_back
// Carries out queued commands: emits padding and data bytes with chunk marks,
// holding one byte back so the final byte of a segment can be closed.
// ----------------------------------------------------------------------------
module acs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  acs_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_res_valid,
    output acs_pkg::t_res o_res,
    input  logic          i_res_ready
);
    import acs_pkg::*;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_FRONT = 2'd1;
    localparam logic [1:0] B_TRAIL = 2'd2;
    localparam logic [1:0] B_FLUSH = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_next_addr, n_next_addr;
    logic [CB_W-1:0]   r_left, n_left;
    logic              r_pend_valid, n_pend_valid;
    logic [7:0]        r_pend_byte, n_pend_byte;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic              r_pend_first, n_pend_first;
    logic              r_pend_end, n_pend_end;
    logic              r_pend_pad, n_pend_pad;
    logic              r_next_first, n_next_first;
    logic [WB_W-1:0]   r_wb, n_wb;
    logic [AW_W-1:0]   r_align, n_align;
    logic [CB_W-1:0]   r_chunk, n_chunk;
    logic              r_pad, n_pad;
    logic [PW_W-1:0]   r_pad_word, n_pad_word;
    logic [KP_W-1:0]   r_kpos, n_kpos;
    logic [AW_W-1:0]   r_apos, n_apos;
    logic [AW_W-1:0]   r_offset, n_offset;
    logic [AW_W-1:0]   r_cnt, n_cnt;
    logic              r_ov;
    t_res              r_res;

    logic              can_emit, emit, push, push_pad, push_rl, flush, front_last;
    logic [7:0]        push_val, pad_val;
    logic [CB_W-1:0]   left_eff, left_dec;
    logic              push_end;
    logic [KP_W-1:0]   kpos_inc;
    logic [AW_W-1:0]   apos_inc;
    t_res              res;

    assign can_emit   = !r_ov || i_res_ready;
    assign left_eff   = (r_left == '0) ? r_chunk : r_left;
    assign left_dec   = left_eff - CB_W'(1);
    assign push_end   = (left_dec == '0);
    assign kpos_inc   = ((WB_W'(r_kpos) + WB_W'(1)) == r_wb) ? '0 : r_kpos + KP_W'(1);
    assign apos_inc   = ((r_apos + AW_W'(1)) == r_align) ? '0 : r_apos + AW_W'(1);
    assign pad_val    = r_pad_word[{r_kpos, 3'b000} +: 8];
    assign front_last = ((r_cnt + AW_W'(1)) == r_offset);

    always_comb begin
        n_state      = r_state;
        n_next_addr  = r_next_addr;
        n_left       = r_left;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        n_pend_addr  = r_pend_addr;
        n_pend_first = r_pend_first;
        n_pend_end   = r_pend_end;
        n_pend_pad   = r_pend_pad;
        n_next_first = r_next_first;
        n_wb         = r_wb;
        n_align      = r_align;
        n_chunk      = r_chunk;
        n_pad        = r_pad;
        n_pad_word   = r_pad_word;
        n_kpos       = r_kpos;
        n_apos       = r_apos;
        n_offset     = r_offset;
        n_cnt        = r_cnt;
        o_cmd_pop    = 1'b0;
        emit         = 1'b0;
        push         = 1'b0;
        push_val     = '0;
        push_pad     = 1'b0;
        push_rl      = 1'b0;
        flush        = 1'b0;
        res.value    = r_pend_byte;
        res.addr     = r_pend_addr;
        res.pad      = r_pend_pad;
        res.first    = r_pend_first;
        res.last     = r_pend_end;
        res.run_last = 1'b0;
        res.err      = ERR_NONE;

        if (can_emit) begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_cmd_valid) begin
                        o_cmd_pop = 1'b1;
                        unique case (i_cmd.op)
                            OP_ERR: begin
                                emit         = 1'b1;
                                res.value    = '0;
                                res.addr     = i_cmd.addr;
                                res.pad      = 1'b0;
                                res.first    = 1'b0;
                                res.last     = 1'b0;
                                res.run_last = 1'b1;
                                res.err      = i_cmd.err;
                            end
                            OP_START: begin
                                n_wb         = i_cmd.wb;
                                n_align      = i_cmd.align;
                                n_chunk      = i_cmd.chunk;
                                n_pad        = i_cmd.pad;
                                n_pad_word   = i_cmd.pad_word;
                                n_pend_valid = 1'b0;
                                n_next_first = 1'b1;
                                n_kpos       = '0;
                                n_apos       = '0;
                                n_cnt        = '0;
                                n_offset     = i_cmd.offset;
                                if (i_cmd.pad) begin
                                    // back up to the boundary and pad up to the start
                                    n_next_addr = i_cmd.addr - ADDR_W'(i_cmd.offset);
                                    n_left      = i_cmd.chunk;
                                    if (i_cmd.offset != '0) begin
                                        n_state = B_FRONT;
                                    end
                                end else begin
                                    // short first chunk runs to the next boundary
                                    n_next_addr = i_cmd.addr;
                                    n_left      = (i_cmd.offset != '0)
                                                  ? CB_W'(i_cmd.align - i_cmd.offset)
                                                  : i_cmd.chunk;
                                end
                            end
                            OP_DATA: begin
                                push     = 1'b1;
                                push_val = i_cmd.data;
                                push_rl  = 1'b1;
                            end
                            OP_END: begin
                                if (r_pad && r_apos != '0) begin
                                    n_state = B_TRAIL;
                                end else begin
                                    flush = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                B_FRONT: begin
                    push     = 1'b1;
                    push_val = pad_val;
                    push_pad = 1'b1;
                    push_rl  = front_last;
                    n_cnt    = r_cnt + AW_W'(1);
                    if (front_last) begin
                        n_state = B_IDLE;
                    end
                end
                B_TRAIL: begin
                    push     = 1'b1;
                    push_val = pad_val;
                    push_pad = 1'b1;
                    if (apos_inc == '0) begin
                        n_state = B_FLUSH;
                    end
                end
                B_FLUSH: begin
                    flush   = 1'b1;
                    n_state = B_IDLE;
                end
            endcase
        end

        // emit the held byte, then hold the new one
        if (push) begin
            emit         = r_pend_valid;
            res.run_last = push_rl;
            n_pend_valid = 1'b1;
            n_pend_byte  = push_val;
            n_pend_addr  = r_next_addr;
            n_pend_pad   = push_pad;
            n_pend_first = r_next_first;
            n_pend_end   = push_end;
            n_next_first = push_end;
            n_left       = push_end ? r_chunk : left_dec;
            n_next_addr  = r_next_addr + ADDR_W'(1);
            n_kpos       = kpos_inc;
            n_apos       = apos_inc;
        end

        // close the segment: the held byte ends its chunk
        if (flush) begin
            emit         = r_pend_valid;
            res.last     = 1'b1;
            res.run_last = 1'b1;
            n_pend_valid = 1'b0;
            n_left       = '0;
            n_next_first = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_pend_valid <= 1'b0;
            r_pad        <= 1'b0;
            r_kpos       <= '0;
            r_apos       <= '0;
            r_cnt        <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_pad        <= n_pad;
            r_kpos       <= n_kpos;
            r_apos       <= n_apos;
            r_cnt        <= n_cnt;
            if (can_emit) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_next_addr  <= n_next_addr;
        r_left       <= n_left;
        r_pend_byte  <= n_pend_byte;
        r_pend_addr  <= n_pend_addr;
        r_pend_first <= n_pend_first;
        r_pend_end   <= n_pend_end;
        r_pend_pad   <= n_pend_pad;
        r_next_first <= n_next_first;
        r_wb         <= n_wb;
        r_align      <= n_align;
        r_chunk      <= n_chunk;
        r_pad_word   <= n_pad_word;
        r_offset     <= n_offset;
        if (can_emit && emit) begin
            r_res <= res;
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_res;

    a_front_needs_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_FRONT |-> r_pad)
        else $error("front padding without padding enabled");

    a_trail_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_TRAIL |-> r_pend_valid)
        else $error("trailing padding with no held byte");

    a_apos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad |-> (r_apos < r_align))
        else $error("alignment position beyond alignment");

    a_err_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.err != ERR_NONE) |-> (o_res.run_last && !o_res.pad))
        else $error("error beat not a single plain beat");

endmodule

// ===== rtl/aligned_chunk_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_chunk_splitter
// Splits a streamed segment (start beat with address, data beats, end beat)
// into aligned write chunks and emits each byte with its address and chunk
// marks. A data or end beat is taken at once when the command queue has
// room. A start beat holds the front end while a bit-serial remainder unit
// runs 13 steps to check the chunk length against the alignment and 32
// steps to find the start offset. Front and trailing padding bytes leave
// the back end at one per cycle while the output is not stalled, so a
// padded start or end keeps the back end busy, while the queue of two
// commands lets the front end take further beats. One byte is always held
// back until the next byte or the end beat, so the last byte of a segment
// appears only once the end beat arrives.
// ----------------------------------------------------------------------------
module aligned_chunk_splitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [39:0]                 s_axis_tdata,  // start_address[31:0], data_byte[39:32]
    input  logic [1:0]                  s_axis_tuser,  // kind[1:0]
    // master stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [47:0]                 m_axis_tdata,  // byte_value[7:0], byte_address[39:8],
                                                       // chunk_first[40], chunk_last[41], zero
    output logic [2:0]                  m_axis_tuser,  // is_padding[0], error[2:1]
    output logic                        m_axis_tlast,  // run_last
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [acs_pkg::PADDR_W-1:0] paddr,
    input  logic [acs_pkg::PDATA_W-1:0] pwdata,
    output logic [acs_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import acs_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    logic                 fr_cmd_valid, q_ready, q_valid, q_pop;
    t_cmd                 fr_cmd, q_cmd;
    logic                 res_valid;
    t_res                 res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.word_bytes  <= WB_W'(2);
            r_cfg.chunk_words <= CW_W'(8);
            r_cfg.align_words <= AW_W'(8);
            r_cfg.pad_enable  <= 1'b0;
            r_cfg.pad_word    <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_WORD_BYTES:  r_cfg.word_bytes  <= pwdata[WB_W-1:0];
                REG_CHUNK_WORDS: r_cfg.chunk_words <= pwdata[CW_W-1:0];
                REG_ALIGN_WORDS: r_cfg.align_words <= pwdata[AW_W-1:0];
                REG_PAD_ENABLE:  r_cfg.pad_enable  <= pwdata[0];
                REG_PAD_WORD:    r_cfg.pad_word    <= pwdata[PW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WORD_BYTES:  prdata = PDATA_W'(r_cfg.word_bytes);
            REG_CHUNK_WORDS: prdata = PDATA_W'(r_cfg.chunk_words);
            REG_ALIGN_WORDS: prdata = PDATA_W'(r_cfg.align_words);
            REG_PAD_ENABLE:  prdata = PDATA_W'(r_cfg.pad_enable);
            REG_PAD_WORD:    prdata = PDATA_W'(r_cfg.pad_word);
            default:         prdata = '0;
        endcase
    end

    acs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_addr      (s_axis_tdata[ADDR_W-1:0]),
        .i_data      (s_axis_tdata[ADDR_W+7:ADDR_W]),
        .i_cfg       (r_cfg),
        .o_cmd_valid (fr_cmd_valid),
        .o_cmd       (fr_cmd),
        .i_cmd_ready (q_ready)
    );

    acs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_cmd_valid),
        .i_data  (fr_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    acs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {6'b0, res.last, res.first, res.addr, res.value};
    assign m_axis_tuser  = {res.err, res.pad};
    assign m_axis_tlast  = res.run_last;

endmodule

// ===== tb/sv/aligned_chunk_splitter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_chunk_splitter_checker
// Follows register writes and accepted input beats, predicts the byte stream
// of the chunk splitter and compares each accepted output beat, field by
// field, with the oldest predicted byte.
// ----------------------------------------------------------------------------
module aligned_chunk_splitter_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [39:0]                 i_s_tdata,  // start_address[31:0], data_byte[39:32]
    input  logic [1:0]                  i_s_tuser,  // kind[1:0]
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [47:0]                 i_m_tdata,  // byte_value[7:0], byte_address[39:8],
                                                    // chunk_first[40], chunk_last[41], zero
    input  logic [2:0]                  i_m_tuser,  // is_padding[0], error[2:1]
    input  logic                        i_m_tlast,  // run_last
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [acs_pkg::PADDR_W-1:0] i_paddr,
    input  logic [acs_pkg::PDATA_W-1:0] i_pwdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_expected_left,
    output int                          o_bytes_checked
);
    import acs_pkg::*;

    t_cfg        regs;

    // settings latched by the start beat, held for the segment
    int unsigned seg_wb;
    int unsigned seg_align;
    int unsigned seg_chunk;
    logic        seg_pad;
    logic [63:0] seg_pad_word;

    logic        in_seg;
    logic [31:0] next_addr;
    int unsigned chunk_left;
    logic        next_first;

    // byte held back until the next byte or the end beat
    logic        held_valid;
    logic [7:0]  held_value;
    logic [31:0] held_addr;
    logic        held_pad;
    logic        held_first;
    logic        held_end;

    t_res        expected_bytes[$];
    int          mismatches = 0;
    int          checked    = 0;

    function automatic void reset_model();
        regs.word_bytes  = 4'd2;
        regs.chunk_words = 13'd8;
        regs.align_words = 7'd8;
        regs.pad_enable  = 1'b0;
        regs.pad_word    = '0;
        seg_wb       = 1;
        seg_align    = 1;
        seg_chunk    = 1;
        seg_pad      = 1'b0;
        seg_pad_word = '0;
        in_seg       = 1'b0;
        next_addr    = '0;
        chunk_left   = 0;
        next_first   = 1'b0;
        held_valid   = 1'b0;
        held_value   = '0;
        held_addr    = '0;
        held_pad     = 1'b0;
        held_first   = 1'b0;
        held_end     = 1'b0;
        expected_bytes.delete();
    endfunction

    function automatic void queue_byte(input logic [7:0] value, input logic [31:0] addr,
                                       input logic pad, input logic first,
                                       input logic last, input logic [1:0] err);
        t_res r;
        r.value    = value;
        r.addr     = addr;
        r.pad      = pad;
        r.first    = first;
        r.last     = last;
        r.run_last = 1'b0;
        r.err      = err;
        expected_bytes = {expected_bytes, r};
    endfunction

    // byte of the pad word at a position counted from the aligned base
    function automatic logic [7:0] pad_byte_at(input int unsigned pos);
        int unsigned k;
        k = pos % seg_wb;
        return seg_pad_word[8*k +: 8];
    endfunction

    // release the held byte and hold the new one in its place
    function automatic void advance_byte(input logic [7:0] value, input logic pad);
        int unsigned left;
        logic        ends;
        if (held_valid)
            queue_byte(held_value, held_addr, held_pad, held_first, held_end, ERR_NONE);
        left = (chunk_left == 0) ? seg_chunk : chunk_left;
        left = left - 1;
        ends = (left == 0);
        held_valid = 1'b1;
        held_value = value;
        held_addr  = next_addr;
        held_pad   = pad;
        held_first = next_first;
        held_end   = ends;
        next_first = ends;
        chunk_left = ends ? seg_chunk : left;
        next_addr  = next_addr + 32'd1;
    endfunction

    function automatic void predict_beat(input logic [1:0] kind, input logic [31:0] addr,
                                         input logic [7:0] data);
        int unsigned wb;
        int unsigned offset;
        int unsigned pos;
        int unsigned trail;
        logic [1:0]  err;
        int          n_prior;
        int          last_idx;
        t_res        tail;
        n_prior = expected_bytes.size();
        if (kind == K_START && !in_seg) begin
            wb = regs.word_bytes;
            if (wb == 0)
                wb = 1;
            else if (wb > 8)
                wb = 8;
            err = ERR_NONE;
            if (regs.align_words == 0 || regs.chunk_words == 0 ||
                (regs.chunk_words % regs.align_words) != 0)
                err = ERR_GEOM;
            else if (regs.align_words * wb > MAX_ALIGN_BYTES)
                err = ERR_ALIGN;
            if (err != ERR_NONE) begin
                queue_byte(8'h00, addr, 1'b0, 1'b0, 1'b0, err);
            end else begin
                seg_wb       = wb;
                seg_align    = regs.align_words * wb;
                seg_chunk    = regs.chunk_words * wb;
                seg_pad      = regs.pad_enable;
                seg_pad_word = regs.pad_word;
                in_seg       = 1'b1;
                held_valid   = 1'b0;
                next_first   = 1'b1;
                offset       = addr % seg_align;
                if (seg_pad) begin
                    // pad from the boundary at or below the start address
                    next_addr  = addr - offset;
                    chunk_left = seg_chunk;
                    for (int unsigned i = 0; i < offset; i++)
                        advance_byte(pad_byte_at(i), 1'b1);
                end else begin
                    // short first chunk up to the next boundary
                    next_addr  = addr;
                    chunk_left = (offset != 0) ? seg_align - offset : seg_chunk;
                end
            end
        end else if (kind == K_DATA && in_seg) begin
            advance_byte(data, 1'b0);
        end else if (kind == K_END && in_seg) begin
            if (seg_pad) begin
                pos   = seg_chunk - chunk_left;
                trail = (seg_align - pos % seg_align) % seg_align;
                for (int unsigned i = 0; i < trail; i++)
                    advance_byte(pad_byte_at(pos + i), 1'b1);
            end
            if (held_valid)
                queue_byte(held_value, held_addr, held_pad, held_first, 1'b1, ERR_NONE);
            in_seg     = 1'b0;
            held_valid = 1'b0;
            chunk_left = 0;
            next_first = 1'b0;
        end
        // mark the last byte this beat caused
        if (expected_bytes.size() > n_prior) begin
            last_idx = expected_bytes.size() - 1;
            tail = expected_bytes[last_idx];
            tail.run_last = 1'b1;
            expected_bytes[last_idx] = tail;
        end
    endfunction

    task automatic flag_beat(input string why, input t_res want, input t_res got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s", $realtime, why);
            $display("  want value %02h addr %08h pad %b first %b last %b tlast %b err %0d",
                     want.value, want.addr, want.pad, want.first, want.last,
                     want.run_last, want.err);
            $display("  got  value %02h addr %08h pad %b first %b last %b tlast %b err %0d",
                     got.value, got.addr, got.pad, got.first, got.last,
                     got.run_last, got.err);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2:0] == 3'd0) begin
                case (i_paddr[PADDR_W-1:3])
                    REG_WORD_BYTES:  regs.word_bytes  = i_pwdata[WB_W-1:0];
                    REG_CHUNK_WORDS: regs.chunk_words = i_pwdata[CW_W-1:0];
                    REG_ALIGN_WORDS: regs.align_words = i_pwdata[AW_W-1:0];
                    REG_PAD_ENABLE:  regs.pad_enable  = i_pwdata[0];
                    REG_PAD_WORD:    regs.pad_word    = i_pwdata[PW_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_beat(i_s_tuser, i_s_tdata[31:0], i_s_tdata[39:32]);
            if (i_m_tvalid && i_m_tready) begin
                got.value    = i_m_tdata[7:0];
                got.addr     = i_m_tdata[39:8];
                got.first    = i_m_tdata[40];
                got.last     = i_m_tdata[41];
                got.pad      = i_m_tuser[0];
                got.err      = i_m_tuser[2:1];
                got.run_last = i_m_tlast;
                checked++;
                if (expected_bytes.size() == 0) begin
                    want = '0;
                    flag_beat("byte with none expected", want, got);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got !== want)
                        flag_beat("byte mismatch", want, got);
                end
            end
        end
        o_fail_count    <= mismatches;
        o_expected_left <= expected_bytes.size();
        o_bytes_checked <= checked;
    end

endmodule

// ===== tb/sv/aligned_chunk_splitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_chunk_splitter_tb
// Drives segments of start, data and end beats through the chunk splitter
// under a range of register settings, with random gaps and back-pressure,
// and gives the verdict from the checker that sits beside the block.
// ----------------------------------------------------------------------------
module aligned_chunk_splitter_tb;
    import acs_pkg::*;

    localparam logic [1:0] K_UNKNOWN    = 2'd3;
    localparam int         HOLD_CYCLES  = 120;
    localparam int         RANDOM_ITEMS = 150;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [47:0]          m_axis_tdata;
    logic [2:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int fail_count;
    int expected_left;
    int bytes_checked;
    int beats_sent     = 0;
    int segments_sent  = 0;
    int settings_used  = 0;
    int random_items   = 0;
    int gap_odds       = 0;
    int stall_odds     = 0;
    int stall_left     = 0;

    int         odds_set[4]    = '{0, 2, 4, 8};
    logic [1:0] stray_kinds[3] = '{K_DATA, K_END, K_UNKNOWN};

    aligned_chunk_splitter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    aligned_chunk_splitter_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tuser       (m_axis_tuser),
        .i_m_tlast       (m_axis_tlast),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_expected_left (expected_left),
        .o_bytes_checked (bytes_checked)
    );

    always #5 i_clk = ~i_clk;

    // back-pressure: now and then hold tready low for a random burst
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left    <= $urandom_range(1, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        // worst case: every item at its largest burst of bytes, each byte stalled
        #8_000_000;
        $display("FAIL aligned_chunk_splitter");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [3:0] wb, input logic [12:0] chunk,
                                  input logic [6:0] align, input logic pad,
                                  input logic [63:0] word);
        write_reg(REG_WORD_BYTES, {60'd0, wb});
        write_reg(REG_CHUNK_WORDS, {51'd0, chunk});
        write_reg(REG_ALIGN_WORDS, {57'd0, align});
        write_reg(REG_PAD_ENABLE, {63'd0, pad});
        write_reg(REG_PAD_WORD, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    task automatic send_beat(input logic [1:0] kind, input logic [31:0] addr,
                             input logic [7:0] data);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    // hold the sender until every predicted byte has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_left != 0) @(posedge i_clk);
    endtask

    // drain, then let a start beat with no bytes finish before a register write
    task automatic settle();
        drain();
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_address();
        case ($urandom_range(0, 3))
            0:       return $urandom & 32'hFFFF_FFC0;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 70);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_length();
        if ($urandom_range(1, 8) == 1)
            return $urandom_range(11, 40);
        return $urandom_range(0, 10);
    endfunction

    task automatic send_segment(input logic [31:0] addr, input int len);
        send_beat(K_START, addr, rand_byte());
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(1, 12) == 1)
                send_beat(($urandom_range(0, 1) != 0) ? K_START : K_UNKNOWN,
                          $urandom, rand_byte());
            send_beat(K_DATA, $urandom, rand_byte());
            if ($urandom_range(1, 40) == 1)
                drain();
        end
        send_beat(K_END, $urandom, rand_byte());
        segments_sent++;
        random_items += len + 2;
    endtask

    task automatic pick_settings(output bit broken);
        logic [3:0]  wb;
        logic [12:0] chunk;
        logic [6:0]  align;
        int unsigned wbc;
        int unsigned mult;
        if ($urandom_range(1, 8) == 1)
            wb = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(9, 15));
        else
            wb = 4'($urandom_range(1, 8));
        wbc   = (wb == 0) ? 1 : (wb > 8) ? 8 : wb;
        align = 7'($urandom_range(1, 64 / wbc));
        mult  = ($urandom_range(1, 10) == 1) ? 8191 / align : $urandom_range(1, 4);
        chunk = 13'(align * mult);
        broken = 1'b0;
        if ($urandom_range(1, 8) == 1) begin
            broken = 1'b1;
            case ($urandom_range(0, 3))
                0: align = 7'd0;
                1: chunk = 13'd0;
                2: begin
                    align = 7'($urandom_range(2, 64 / wbc));
                    chunk = 13'(align * $urandom_range(1, 4) + 1);
                end
                default: begin
                    align = 7'(64 / wbc + 1 + $urandom_range(0, 10));
                    chunk = 13'(align);
                end
            endcase
        end
        apply_settings(wb, chunk, align, 1'($urandom_range(0, 1)), {$urandom, $urandom});
    endtask

    task automatic run_phase(input bit broken);
        int n_segs;
        // no idling in the closing stretch
        if (random_items >= RANDOM_ITEMS - 30) begin
            gap_odds   = 0;
            stall_odds = 0;
        end else begin
            gap_odds   = odds_set[$urandom_range(0, 3)];
            stall_odds = odds_set[$urandom_range(0, 3)];
        end
        if (broken) begin
            send_beat(K_START, pick_address(), rand_byte());
            send_beat(K_DATA, $urandom, rand_byte());
            send_beat(K_END, $urandom, rand_byte());
        end else begin
            n_segs = $urandom_range(1, 4);
            repeat (n_segs) begin
                if ($urandom_range(1, 6) == 1)
                    send_beat(stray_kinds[$urandom_range(0, 2)], $urandom, rand_byte());
                send_segment(pick_address(), pick_length());
            end
        end
        settle();
    endtask

    initial begin
        bit broken;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= K_START;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // settings after reset: stray beats, short first chunk, empty segment
        gap_odds   = 4;
        stall_odds = 3;
        send_beat(K_DATA, $urandom, rand_byte());
        send_beat(K_END, $urandom, rand_byte());
        send_beat(K_UNKNOWN, $urandom, rand_byte());
        send_beat(K_START, 32'h2000_000E, rand_byte());
        send_beat(K_DATA, $urandom, 8'h00);
        send_beat(K_DATA, $urandom, 8'hFF);
        send_beat(K_START, $urandom, rand_byte());
        send_beat(K_UNKNOWN, $urandom, rand_byte());
        send_beat(K_DATA, $urandom, 8'h5A);
        send_beat(K_DATA, $urandom, 8'hC3);
        send_beat(K_END, $urandom, rand_byte());
        send_beat(K_START, 32'h0000_0000, rand_byte());
        send_beat(K_END, $urandom, rand_byte());
        settle();

        // widest alignment with padding: full front and trailing pad, address wrap
        apply_settings(4'd8, 13'd8, 7'd8, 1'b1, 64'h0123_4567_89AB_CDEF);
        send_beat(K_START, 32'hFFFF_FFFF, 8'h00);
        send_beat(K_DATA, 32'h0000_0000, 8'hFF);
        send_beat(K_DATA, 32'hFFFF_FFFF, 8'h00);
        send_beat(K_END, $urandom, rand_byte());
        send_beat(K_START, 32'h0000_0007, 8'hFF);
        send_beat(K_END, $urandom, rand_byte());
        settle();

        // bad geometry; following data and end beats are dropped
        apply_settings(4'd15, 13'd12, 7'd8, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(K_START, 32'h1234_5678, rand_byte());
        send_beat(K_DATA, $urandom, rand_byte());
        send_beat(K_END, $urandom, rand_byte());
        settle();
        apply_settings(4'd1, 13'd0, 7'd0, 1'b1, 64'h0);
        send_beat(K_START, 32'hFFFF_FFFF, rand_byte());
        settle();
        apply_settings(4'd1, 13'd8128, 7'd127, 1'b1, 64'($urandom));
        send_beat(K_START, 32'h8000_0001, rand_byte());
        settle();

        // corner settings, then random ones
        apply_settings(4'd0, 13'd8191, 7'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        run_phase(1'b0);
        apply_settings(4'd15, 13'd8, 7'd8, 1'b1, {$urandom, $urandom});
        run_phase(1'b0);
        apply_settings(4'd1, 13'd8128, 7'd64, 1'b0, 64'h0);
        run_phase(1'b0);
        apply_settings(4'd3, 13'd21, 7'd7, 1'b1, {$urandom, $urandom});
        run_phase(1'b0);
        while (random_items < RANDOM_ITEMS) begin
            pick_settings(broken);
            run_phase(broken);
        end

        $display("Covered %0d input beats in %0d segments over %0d register settings,",
                 beats_sent, segments_sent, settings_used);
        $display("%0d output bytes checked: padded and unpadded runs, bad geometry, wrap.",
                 bytes_checked);
        if (fail_count == 0 && expected_left == 0) begin
            $display("PASS aligned_chunk_splitter");
        end else begin
            $display("%0d mismatches, %0d bytes still expected", fail_count, expected_left);
            $display("FAIL aligned_chunk_splitter");
        end
        $finish;
    end

endmodule
